// File: rtl/rbs_pkg.sv
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants of the ray/box slab test core.
// ----------------------------------------------------------------------------
package rbs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int AXES      = 3;
   // dividend is the 33-bit difference magnitude scaled by the fraction bits
   localparam int DIV_W     = 33 + FRAC_BITS;
   // input register, one stage per quotient bit, saturation, ordering
   localparam int LANE_LAT  = DIV_W + 3;

   localparam logic [30:0] MIN_EXIT_RESET = 31'd66;

   localparam logic REQ_SET_RAY = 1'b0;
   localparam logic REQ_BOX     = 1'b1;

   localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] DIST_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic              req_type;
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic signed [31:0] max_dist;
   } rbs_req_type;

   typedef struct packed {
      logic              hit;
      logic signed [31:0] entry_distance;
   } rbs_rsp_type;

   // what travels beside the lanes
   typedef struct packed {
      logic              valid;
      logic [AXES-1:0]   dir_nz;
      logic signed [31:0] max_dist;
   } rbs_ctl_type;

   typedef struct packed {
      logic signed [31:0] near;
      logic signed [31:0] far;
   } rbs_span_type;

endpackage

// File: rtl/rbs_sdiv.sv
// ----------------------------------------------------------------------------
// rbs_sdiv
// Pipelined signed divider: ((bound - origin) << FRAC_BITS) / divisor,
// truncated toward zero and saturated to 32 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module rbs_sdiv
   import rbs_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] bound,
   input  logic signed [31:0] origin,
   input  logic signed [31:0] divisor,
   output logic signed [31:0] quot
);

   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic [31:0]        div_mag;

   logic [31:0]        rem_ff [0:DIV_W];
   logic [DIV_W-1:0]   nq_ff  [0:DIV_W];
   logic [31:0]        dv_ff  [0:DIV_W];
   logic               neg_ff [0:DIV_W];

   logic [DIV_W-1:0]   mag;
   logic               over_pos;
   logic               over_neg;
   logic signed [31:0] quot_in;
   logic signed [31:0] quot_ff;

   assign diff     = {bound[31], bound} - {origin[31], origin};
   assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
   assign div_mag  = divisor[31] ? 32'(-divisor) : 32'(divisor);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         nq_ff[0]  <= {diff_mag, {FRAC_BITS{1'b0}}};
         dv_ff[0]  <= div_mag;
         neg_ff[0] <= diff[32] ^ divisor[31];
      end
   end

   for (genvar k = 0; k < DIV_W; k++) begin : g_stage
      logic [32:0] trial;
      logic [32:0] sub;

      assign trial = {rem_ff[k], nq_ff[k][DIV_W-1]};
      assign sub   = trial - {1'b0, dv_ff[k]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!sub[32]) begin
               rem_ff[k+1] <= sub[31:0];
               nq_ff[k+1]  <= {nq_ff[k][DIV_W-2:0], 1'b1};
            end else begin
               rem_ff[k+1] <= trial[31:0];
               nq_ff[k+1]  <= {nq_ff[k][DIV_W-2:0], 1'b0};
            end
            dv_ff[k+1]  <= dv_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   assign mag      = nq_ff[DIV_W];
   assign over_pos = |mag[DIV_W-1:31];
   assign over_neg = (|mag[DIV_W-1:32]) | (mag[31] & (|mag[30:0]));

   always_comb begin
      if (neg_ff[DIV_W]) begin
         quot_in = over_neg ? DIST_MIN : 32'(-mag[31:0]);
      end else begin
         quot_in = over_pos ? DIST_MAX : 32'(mag[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// File: rtl/rbs_lane.sv
// ----------------------------------------------------------------------------
// rbs_lane
// One axis: both slab distances through two dividers, then ordered.
// ----------------------------------------------------------------------------
module rbs_lane
   import rbs_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic signed [31:0] bound_lo,
   input  logic signed [31:0] bound_hi,
   input  logic signed [31:0] origin,
   input  logic signed [31:0] direction,
   output rbs_span_type       span
);

   logic signed [31:0] t0;
   logic signed [31:0] t1;
   rbs_span_type       span_in;
   rbs_span_type       span_ff;

   rbs_sdiv u_div_lo (
      .clock   (clock),
      .en      (en),
      .bound   (bound_lo),
      .origin  (origin),
      .divisor (direction),
      .quot    (t0)
   );

   rbs_sdiv u_div_hi (
      .clock   (clock),
      .en      (en),
      .bound   (bound_hi),
      .origin  (origin),
      .divisor (direction),
      .quot    (t1)
   );

   always_comb begin
      if (t0 < t1) begin
         span_in.near = t0;
         span_in.far  = t1;
      end else begin
         span_in.near = t1;
         span_in.far  = t0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         span_ff <= span_in;
      end
   end

   assign span = span_ff;

endmodule

// File: rtl/rbs_merge.sv
// ----------------------------------------------------------------------------
// rbs_merge
// Combines the three axis spans into entry/exit distances and the hit flag.
// ----------------------------------------------------------------------------
module rbs_merge
   import rbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  rbs_span_type [AXES-1:0]  span,
   input  rbs_ctl_type              ctl,
   input  logic [30:0]              min_distance,
   output logic                     out_valid,
   output rbs_rsp_type              out_data
);

   logic signed [31:0] dmin;
   logic signed [31:0] dmax;
   logic               miss;
   rbs_rsp_type        data_in;
   rbs_rsp_type        data_ff;
   logic               valid_ff;

   // axes in order; once missed, later axes no longer matter
   always_comb begin
      dmin = DIST_MIN;
      dmax = ctl.max_dist;
      miss = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         if (!miss && ctl.dir_nz[i]) begin
            if (span[i].far < dmax) begin
               dmax = span[i].far;
            end
            if (span[i].near > dmin) begin
               dmin = span[i].near;
            end
            if (dmin > dmax || dmax < $signed({1'b0, min_distance})) begin
               miss = 1'b1;
            end
         end
      end
      data_in.hit            = !miss;
      data_in.entry_distance = miss ? 32'sd0 : dmin;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Ray against axis-aligned box slab test in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A set-ray transfer (req_type 0) loads origin, direction and farthest
// distance and produces no response; a box transfer (req_type 1) produces one
// response. One item is taken per cycle while req_stall is low. A box response
// passes through the three axis lanes, whose pipelined dividers retire one
// quotient bit per stage over 33 + FRAC_BITS stages, and then the merge and
// output registers. A two-entry output (register plus skid) keeps requests
// flowing while one response waits; req_stall rises only when both are
// occupied, and the whole pipeline holds while it is high.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core
   import rbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rbs_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rbs_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [30:0] csr_data
);

   logic               en;
   logic               req_acc;
   logic [30:0]        min_exit_ff;

   logic signed [31:0] ray_org_ff [AXES];
   logic signed [31:0] ray_dir_ff [AXES];
   logic signed [31:0] ray_max_ff;

   logic signed [31:0] lo_bound [AXES];
   logic signed [31:0] hi_bound [AXES];
   logic [AXES-1:0]    dir_nz;

   rbs_ctl_type        ctl_ff [0:LANE_LAT-1];
   rbs_span_type [AXES-1:0] span;

   logic               pipe_valid;
   rbs_rsp_type        pipe_data;

   logic               rsp_valid_ff, rsp_valid_in;
   rbs_rsp_type        rsp_data_ff, rsp_data_in;
   logic               skid_valid_ff, skid_valid_in;
   rbs_rsp_type        skid_data_ff, skid_data_in;
   logic               take;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_exit_ff <= MIN_EXIT_RESET;
      end else if (csr_valid && csr_ready) begin
         min_exit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            ray_org_ff[i] <= '0;
            ray_dir_ff[i] <= '0;
         end
         ray_max_ff <= '0;
      end else if (req_acc && req_data.req_type == REQ_SET_RAY) begin
         ray_org_ff[0] <= req_data.first_x;
         ray_org_ff[1] <= req_data.first_y;
         ray_org_ff[2] <= req_data.first_z;
         ray_dir_ff[0] <= req_data.second_x;
         ray_dir_ff[1] <= req_data.second_y;
         ray_dir_ff[2] <= req_data.second_z;
         ray_max_ff    <= req_data.max_dist;
      end
   end

   assign lo_bound[0] = req_data.first_x;
   assign lo_bound[1] = req_data.first_y;
   assign lo_bound[2] = req_data.first_z;
   assign hi_bound[0] = req_data.second_x;
   assign hi_bound[1] = req_data.second_y;
   assign hi_bound[2] = req_data.second_z;

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      assign dir_nz[a] = ray_dir_ff[a] != 32'sd0;

      rbs_lane u_lane (
         .clock     (clock),
         .en        (en),
         .bound_lo  (lo_bound[a]),
         .bound_hi  (hi_bound[a]),
         .origin    (ray_org_ff[a]),
         .direction (ray_dir_ff[a]),
         .span      (span[a])
      );
   end

   // sideband travels in step with the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_LAT; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (en) begin
         ctl_ff[0].valid    <= req_acc && req_data.req_type == REQ_BOX;
         ctl_ff[0].dir_nz   <= dir_nz;
         ctl_ff[0].max_dist <= ray_max_ff;
         for (int s = 1; s < LANE_LAT; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   rbs_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .span         (span),
      .ctl          (ctl_ff[LANE_LAT-1]),
      .min_distance (min_exit_ff),
      .out_valid    (pipe_valid),
      .out_data     (pipe_data)
   );

   // output register with one skid entry
   assign take = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pipe_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = pipe_data;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a pending response");

   a_skid_drains_to_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && take |=> rsp_valid_ff && !skid_valid_ff)
      else $error("skid entry lost on output transfer");

   a_miss_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.hit |-> rsp_data_ff.entry_distance == 32'sd0)
      else $error("miss response with nonzero entry distance");

   a_ray_load: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.req_type == REQ_SET_RAY
      |=> ray_max_ff == $past(req_data.max_dist) && ray_dir_ff[0] == $past(req_data.second_x))
      else $error("ray state not loaded");
`endif

endmodule

// File: sim/ray_box_slab_checker.sv
// ----------------------------------------------------------------------------
// ray_box_slab_checker
// Watches the request, response and register channels of the slab test core,
// predicts every box response from its own copy of the ray and min distance,
// and compares each response transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module ray_box_slab_checker
   import rbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  rbs_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rbs_rsp_type rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [30:0] csr_data,
   output int          pending,
   output int          fail_count
);

   logic signed [31:0] ray_org [AXES];
   logic signed [31:0] ray_dir [AXES];
   logic signed [31:0] ray_reach;
   logic [30:0]        min_exit;
   rbs_rsp_type        hits_due [$];

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic longint slab_quotient(logic signed [31:0] bound,
                                            logic signed [31:0] org,
                                            logic signed [31:0] dir);
      longint q;
      q = ((longint'(bound) - longint'(org)) * (64'sd1 <<< FRAC_BITS)) / longint'(dir);
      if (q > longint'(DIST_MAX)) q = longint'(DIST_MAX);
      if (q < longint'(DIST_MIN)) q = longint'(DIST_MIN);
      return q;
   endfunction

   function automatic rbs_rsp_type box_outcome(rbs_req_type b);
      logic signed [31:0] lo [AXES];
      logic signed [31:0] hi [AXES];
      longint entry_d, exit_d, t0, t1;
      bit miss;
      rbs_rsp_type r;
      lo[0] = b.first_x;  lo[1] = b.first_y;  lo[2] = b.first_z;
      hi[0] = b.second_x; hi[1] = b.second_y; hi[2] = b.second_z;
      entry_d = longint'(DIST_MIN);
      exit_d = longint'(ray_reach);
      miss = 0;
      for (int a = 0; a < AXES; a++) begin
         if (!miss && ray_dir[a] != 0) begin
            t0 = slab_quotient(lo[a], ray_org[a], ray_dir[a]);
            t1 = slab_quotient(hi[a], ray_org[a], ray_dir[a]);
            if (t0 > t1) begin
               t0 = t0 ^ t1; t1 = t0 ^ t1; t0 = t0 ^ t1;
            end
            if (t1 < exit_d) exit_d = t1;
            if (t0 > entry_d) entry_d = t0;
            if (entry_d > exit_d || exit_d < longint'(min_exit)) miss = 1;
         end
      end
      r.hit = !miss;
      r.entry_distance = miss ? 32'sd0 : entry_d[31:0];
      return r;
   endfunction

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rbs_rsp_type want;
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            ray_org[a] = '0;
            ray_dir[a] = '0;
         end
         ray_reach = '0;
         min_exit = MIN_EXIT_RESET;
         hits_due.delete();
      end else begin
         if (csr_valid && csr_ready) min_exit = csr_data;
         if (req_valid && !req_stall) begin
            if (req_data.req_type == REQ_SET_RAY) begin
               ray_org[0] = req_data.first_x;
               ray_org[1] = req_data.first_y;
               ray_org[2] = req_data.first_z;
               ray_dir[0] = req_data.second_x;
               ray_dir[1] = req_data.second_y;
               ray_dir[2] = req_data.second_z;
               ray_reach = req_data.max_dist;
            end else begin
               hits_due.push_back(box_outcome(req_data));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (hits_due.size() == 0) begin
               report("response without request", 1, 0);
            end else begin
               want = hits_due.pop_front();
               if (rsp_data.hit !== want.hit)
                  report("hit", longint'(rsp_data.hit), longint'(want.hit));
               if (rsp_data.entry_distance !== want.entry_distance)
                  report("entry_distance", rsp_data.entry_distance, want.entry_distance);
            end
         end
      end
      pending = hits_due.size();
   end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random rays and boxes into the slab test core with
// random request gaps and response stalls, across several min distance settings; the
// checker beside the core predicts and compares the responses.
// ----------------------------------------------------------------------------
module testbench;
   import rbs_pkg::*;

   localparam int SETTLE = LANE_LAT + 12;
   localparam int LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   rbs_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rbs_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [30:0] csr_data;
   int          pending;
   int          fail_count;
   int          cycles;
   bit          quiet;
   int          ray_ou [AXES];
   int          ray_du [AXES];

   ray_box_slab_test_core DUT (.*);

   ray_box_slab_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side stalls in random bursts unless quiet
   initial begin
      int left;
      left = 0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (left == 0 && !quiet && $urandom_range(0, 5) == 0) left = $urandom_range(1, 4);
         rsp_stall <= (left > 0);
         if (left > 0) left--;
      end
   end

   task automatic send(input rbs_req_type item);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic rbs_req_type make_item(logic kind, logic signed [31:0] a,
         logic signed [31:0] b, logic signed [31:0] c, logic signed [31:0] d,
         logic signed [31:0] e, logic signed [31:0] f, logic signed [31:0] g);
      rbs_req_type r;
      r.req_type = kind;
      r.first_x = a;  r.first_y = b;  r.first_z = c;
      r.second_x = d; r.second_y = e; r.second_z = f;
      r.max_dist = g;
      return r;
   endfunction

   function automatic rbs_req_type noise_item();
      return make_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
   endfunction

   // ray with small integer origin and direction so that boxes along it can hit
   task automatic send_ray();
      logic signed [31:0] reach;
      for (int a = 0; a < AXES; a++) begin
         ray_ou[a] = int'($urandom_range(0, 100)) - 50;
         ray_du[a] = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(0, 6)) - 3;
      end
      case ($urandom_range(0, 5))
         0: reach = $urandom;
         1: reach = -(int'($urandom_range(0, 50)) <<< 16);
         default: reach = int'($urandom_range(1, 60)) <<< 16;
      endcase
      send(make_item(REQ_SET_RAY, ray_ou[0] <<< 16, ray_ou[1] <<< 16, ray_ou[2] <<< 16,
                     ray_du[0] <<< 16, ray_du[1] <<< 16, ray_du[2] <<< 16, reach));
   endtask

   task automatic send_box_on_ray();
      int t, rad, c;
      logic signed [31:0] lo [AXES];
      logic signed [31:0] hi [AXES];
      t = $urandom_range(0, 40);
      for (int a = 0; a < AXES; a++) begin
         rad = $urandom_range(0, 6);
         c = ray_ou[a] + ray_du[a] * t + int'($urandom_range(0, 4)) - 2;
         lo[a] = ((c - rad) <<< 16) + int'($urandom_range(0, 65535));
         hi[a] = (c + rad) <<< 16;
         if ($urandom_range(0, 4) == 0) begin
            hi[a] = lo[a];
            lo[a] = (c + rad) <<< 16;
         end
      end
      send(make_item(REQ_BOX, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom));
   endtask

   task automatic write_min_exit(input logic [30:0] value);
      req_valid <= 0;
      wait (pending == 0);
      repeat (SETTLE) @(negedge clock);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   initial begin
      logic [30:0] settings [5];
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_data = '0;
      quiet = 0;
      reset = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // box against the cleared ray: no axis counts, so a hit at the minimum
      send(make_item(REQ_BOX, 32'sd5, -32'sd5, 32'sd0, 32'sd9, 32'sd9, 32'sd9, 32'sd0));
      // extremes: saturating quotients through a tiny direction
      send(make_item(REQ_SET_RAY, DIST_MIN, DIST_MAX, 32'sd0, 32'sd1, -32'sd1, 32'sd0,
                     DIST_MAX));
      send(make_item(REQ_BOX, DIST_MAX, DIST_MIN, DIST_MIN, DIST_MAX, DIST_MAX, DIST_MAX,
                     DIST_MIN));
      send(make_item(REQ_BOX, DIST_MIN, DIST_MAX, DIST_MAX, DIST_MIN, DIST_MIN, DIST_MIN,
                     DIST_MAX));
      // plain ray along x, box in front, behind, reversed bounds, equal bounds, beyond reach
      send(make_item(REQ_SET_RAY, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sd0, 32'sd0,
                     32'sh100000));
      send(make_item(REQ_BOX, 32'sh20000, -32'sh10000, -32'sh10000, 32'sh40000, 32'sh10000,
                     32'sh10000, 32'sd0));
      send(make_item(REQ_BOX, -32'sh40000, -32'sh10000, -32'sh10000, -32'sh20000,
                     32'sh10000, 32'sh10000, 32'sd0));
      send(make_item(REQ_BOX, 32'sh40000, 32'sh10000, 32'sh10000, 32'sh20000,
                     -32'sh10000, -32'sh10000, 32'sd0));
      send(make_item(REQ_BOX, 32'sh30000, 32'sd0, 32'sd0, 32'sh30000, 32'sd0, 32'sd0,
                     32'sd0));
      send(make_item(REQ_BOX, 32'sh200000, 32'sd0, 32'sd0, 32'sh300000, 32'sd0, 32'sd0,
                     32'sd0));
      // negative directions on all axes, negative farthest distance
      send(make_item(REQ_SET_RAY, 32'sh50000, 32'sh50000, 32'sh50000, -32'sh10000,
                     -32'sh20000, -32'sh8000, -32'sh10000));
      send(make_item(REQ_BOX, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sh10000, 32'sh10000,
                     32'sd0));
      send(make_item(REQ_SET_RAY, 32'sh50000, 32'sh50000, 32'sh50000, -32'sh10000,
                     -32'sh20000, -32'sh8000, DIST_MAX));
      send(make_item(REQ_BOX, 32'sd0, 32'sd0, 32'sd0, 32'sh10000, 32'sh10000, 32'sh10000,
                     32'sd0));
      send(make_item(REQ_BOX, 32'sh48000, 32'sh48000, 32'sh48000, 32'sh60000, 32'sh60000,
                     32'sh60000, 32'sd0));
      for (int k = 0; k < 6; k++) send(noise_item());

      settings[0] = 31'd0;
      settings[1] = 31'h7fff_ffff;
      settings[2] = 31'($urandom_range(0, 32'h000f_ffff));
      settings[3] = 31'($urandom);
      settings[4] = MIN_EXIT_RESET;
      for (int p = 0; p < 5; p++) begin
         write_min_exit(settings[p]);
         if (p == 4) quiet = 1;
         for (int n = 0; n < 130; n++) begin
            case ($urandom_range(0, 9))
               0: send(noise_item());
               1: send_ray();
               default: send_box_on_ray();
            endcase
         end
      end
      req_valid <= 0;

      wait (pending == 0);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/rbs_pkg.sv
rtl/rbs_sdiv.sv
rtl/rbs_lane.sv
rtl/rbs_merge.sv
rtl/ray_box_slab_test_core.sv
sim/ray_box_slab_checker.sv
sim/testbench.sv
